FILE: rtl/assert_macros.svh
// Assertion macros shared by the framer RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/tlvf_pkg.sv
// Types, codes and constants of the TLV record framer.
// No dependencies.
package tlvf_pkg;

  localparam int NUM_TYPES = 8;
  localparam int CNT_IDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int MAX_RES   = 4;
  localparam logic [7:0] BYTE_MASK = 8'hff;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  typedef struct packed {
    op_t         op;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic [7:0]  data_byte;
    logic [2:0]  type_index;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic        frame_end;
    logic [15:0] count_value;
  } res_t;

  typedef struct packed {
    logic [2:0]           cnt;
    res_t [MAX_RES-1:0]   res;
  } bundle_t;

endpackage

FILE: rtl/tlvf_skid.sv
// Input register with skid entry for the framer's input channel.
// Depends on tlvf_pkg.
`include "assert_macros.svh"
module tlvf_skid (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  tlvf_pkg::item_t in_item,
  output logic            main_valid,
  output tlvf_pkg::item_t main_item,
  input  logic            pop
);

  logic            main_valid_r, main_valid_nxt;
  logic            skid_valid_r, skid_valid_nxt;
  tlvf_pkg::item_t main_r, main_nxt;
  tlvf_pkg::item_t skid_r, skid_nxt;
  logic            in_acc;

  assign in_stall   = skid_valid_r;
  assign in_acc     = in_valid & ~skid_valid_r;
  assign main_valid = main_valid_r;
  assign main_item  = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (pop || !main_valid_r) begin
      main_valid_nxt = skid_valid_r | in_acc;
      main_nxt       = skid_valid_r ? skid_r : in_item;
      skid_valid_nxt = 1'b0;
    end else if (in_acc) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  `ASSERT_RST(a_skid_needs_main, clk, rst_n, skid_valid_r |-> main_valid_r, "skid full, main empty")

endmodule

FILE: rtl/tlvf_core.sv
// Framing state (length, checksum, per-type counters) and result bundle logic.
// Depends on tlvf_pkg.
`include "assert_macros.svh"
module tlvf_core (
  input  logic              clk,
  input  logic              rst_n,
  input  tlvf_pkg::item_t   item,
  input  logic              advance,
  output tlvf_pkg::bundle_t bundle
);

  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [15:0] type_counts_r   [tlvf_pkg::NUM_TYPES];
  logic [15:0] type_counts_nxt [tlvf_pkg::NUM_TYPES];

  logic [7:0]  sum_add;
  logic [15:0] left_dec;
  logic [8:0]  tidx_wide;
  logic        tidx_ok;
  logic [15:0] read_val;

  assign sum_add   = running_sum_r + item.data_byte;
  assign left_dec  = bytes_left_r - 16'd1;
  assign tidx_wide = 9'(item.type_index);
  assign tidx_ok   = tidx_wide < 9'(tlvf_pkg::NUM_TYPES);
  assign read_val  = tidx_ok ? type_counts_r[tidx_wide[tlvf_pkg::CNT_IDX_W-1:0]] : 16'd0;

  always_comb begin
    for (int i = 0; i < tlvf_pkg::NUM_TYPES; i++) begin
      type_counts_nxt[i] = type_counts_r[i];
      if (item.op == tlvf_pkg::OP_CLEAR) begin
        type_counts_nxt[i] = 16'd0;
      end else if (item.op == tlvf_pkg::OP_START && item.frame_type == 8'(i)) begin
        type_counts_nxt[i] = type_counts_r[i] + 16'd1;
      end
    end
  end

  always_comb begin
    bundle          = '0;
    bytes_left_nxt  = bytes_left_r;
    running_sum_nxt = running_sum_r;
    case (item.op)
      tlvf_pkg::OP_START: begin
        bundle.res[0].out_byte  = item.frame_type;
        bundle.res[1].out_byte  = item.frame_length[7:0] & tlvf_pkg::BYTE_MASK;
        bundle.res[2].out_byte  = item.frame_length[15:8];
        bundle.res[3].frame_end = 1'b1;
        bundle.cnt              = (item.frame_length == 16'd0) ? 3'd4 : 3'd3;
        running_sum_nxt         = 8'd0;
        bytes_left_nxt          = item.frame_length;
      end
      tlvf_pkg::OP_DATA: begin
        if (bytes_left_r != 16'd0) begin
          bundle.res[0].out_byte = item.data_byte;
          bytes_left_nxt         = left_dec;
          if (left_dec == 16'd0) begin
            bundle.res[1].out_byte  = sum_add;
            bundle.res[1].frame_end = 1'b1;
            bundle.cnt              = 3'd2;
            running_sum_nxt         = 8'd0;
          end else begin
            bundle.cnt      = 3'd1;
            running_sum_nxt = sum_add;
          end
        end
      end
      tlvf_pkg::OP_CLEAR: begin
        bundle.cnt = 3'd0;
      end
      tlvf_pkg::OP_READ: begin
        bundle.res[0].kind        = tlvf_pkg::KIND_COUNT;
        bundle.res[0].count_value = read_val;
        bundle.cnt                = 3'd1;
      end
      default: begin
        bundle.cnt = 3'd0;
      end
    endcase
    for (int k = 0; k < tlvf_pkg::MAX_RES; k++) begin
      if (item.op != tlvf_pkg::OP_READ) begin
        bundle.res[k].kind = tlvf_pkg::KIND_FRAME;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r  <= 16'd0;
      running_sum_r <= 8'd0;
      for (int i = 0; i < tlvf_pkg::NUM_TYPES; i++) begin
        type_counts_r[i] <= 16'd0;
      end
    end else if (advance) begin
      bytes_left_r  <= bytes_left_nxt;
      running_sum_r <= running_sum_nxt;
      for (int i = 0; i < tlvf_pkg::NUM_TYPES; i++) begin
        type_counts_r[i] <= type_counts_nxt[i];
      end
    end
  end

  `ASSERT_RST(a_start_loads_len, clk, rst_n, (advance && item.op == tlvf_pkg::OP_START) |=> (bytes_left_r == $past(item.frame_length)), "start did not load length")
  `ASSERT_RST(a_sum_idle_zero, clk, rst_n, (bytes_left_r == 16'd0) |-> (running_sum_r == 8'd0), "checksum left over with no open frame")

endmodule

FILE: rtl/tlvf_serializer.sv
// Result register: holds one item's results and hands them out one beat at a time.
// Depends on tlvf_pkg.
`include "assert_macros.svh"
module tlvf_serializer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  tlvf_pkg::bundle_t bundle,
  output logic              load_ok,
  output logic              out_valid,
  input  logic              out_stall,
  output tlvf_pkg::res_t    out_res
);

  logic [2:0]                          left_r, left_nxt;
  tlvf_pkg::res_t [tlvf_pkg::MAX_RES-1:0] ent_r, ent_nxt;
  logic                                take;

  assign out_valid = left_r != 3'd0;
  assign take      = out_valid & ~out_stall;
  assign load_ok   = (left_r == 3'd0) || (left_r == 3'd1 && !out_stall);
  assign out_res   = ent_r[0];

  always_comb begin
    left_nxt = left_r;
    ent_nxt  = ent_r;
    if (load) begin
      left_nxt = bundle.cnt;
      ent_nxt  = bundle.res;
    end else if (take) begin
      left_nxt = left_r - 3'd1;
      for (int k = 0; k < tlvf_pkg::MAX_RES - 1; k++) begin
        ent_nxt[k] = ent_r[k+1];
      end
      ent_nxt[tlvf_pkg::MAX_RES-1] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= 3'd0;
    end else begin
      left_r <= left_nxt;
    end
    ent_r <= ent_nxt;
  end

  `ASSERT_RST(a_left_max, clk, rst_n, left_r <= 3'(tlvf_pkg::MAX_RES), "result count overflow")
  `ASSERT_RST(a_left_dec, clk, rst_n, (take && left_r > 3'd1) |=> (left_r == $past(left_r) - 3'd1), "beat not retired")

endmodule

FILE: rtl/tlv_record_framer.sv
// TLV record framer: builds type/length/payload/checksum byte records and
// keeps per-type frame counters.
// Input channel (in_valid/in_stall) takes ops: start frame, payload byte,
// clear counters, read counter. Result channel (out_valid/out_stall) gives
// one result per beat: a stream byte (out_kind 0, out_frame_end on the
// checksum byte) or a counter answer (out_kind 1).
// An accepted beat waits in the input register until the result register
// can take it; the core then turns it into results loaded there.
// Throughput: one input beat per cycle while each item gives at most one
// result and out_stall is low. The result register sends one beat per cycle
// unless stalled, so a start item gives 3 results (4 for zero length) and the
// closing payload byte 2; the input side keeps taking beats into a two-entry
// input register meanwhile.
// in_stall is a register bit; it rises when both input entries are full.
// A stalled result stays on the out_ ports unchanged.
// Reset (synchronous, rst_n low) empties both stages, closes any open frame
// and zeroes all counters; no clearing pass is needed.
// Depends on tlvf_pkg, tlvf_skid, tlvf_core and tlvf_serializer.
module tlv_record_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_frame_type,
  input  logic [15:0] in_frame_length,
  input  logic [7:0]  in_data_byte,
  input  logic [2:0]  in_type_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_out_byte,
  output logic        out_frame_end,
  output logic [15:0] out_count_value
);

  tlvf_pkg::item_t   in_item;
  tlvf_pkg::item_t   main_item;
  tlvf_pkg::bundle_t bundle;
  tlvf_pkg::res_t    out_res;
  logic              main_valid;
  logic              load_ok;
  logic              advance;

  assign in_item.op           = tlvf_pkg::op_t'(in_op);
  assign in_item.frame_type   = in_frame_type;
  assign in_item.frame_length = in_frame_length;
  assign in_item.data_byte    = in_data_byte;
  assign in_item.type_index   = in_type_index;

  assign advance = main_valid & load_ok;

  tlvf_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .main_valid (main_valid),
    .main_item  (main_item),
    .pop        (advance)
  );

  tlvf_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (main_item),
    .advance (advance),
    .bundle  (bundle)
  );

  tlvf_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .bundle    (bundle),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind        = out_res.kind;
  assign out_out_byte    = out_res.out_byte;
  assign out_frame_end   = out_res.frame_end;
  assign out_count_value = out_res.count_value;

endmodule
